[rtl/smeu_pkg.sv]
// Package for the stack machine execute unit.
// Holds opcode and status codes, FSM state type and control/status structs.
// No dependencies.
package smeu_pkg;

	localparam int DATA_W    = 32;
	localparam int OP_W      = 4;
	localparam int ST_W      = 3;
	localparam int DIV_STEPS = 32;

	typedef enum logic [OP_W-1:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_PUSH1    = 4'd4,
		OP_PUSH0    = 4'd5,
		OP_PUSHIMM  = 4'd6,
		OP_RET      = 4'd7,
		OP_RETBOOL  = 4'd8,
		OP_RETS32   = 4'd9,
		OP_JMP      = 4'd10,
		OP_JMPTRUE  = 4'd11,
		OP_JMPFALSE = 4'd12
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_RUNNING   = 3'd0,
		ST_RETURNED  = 3'd1,
		ST_DIVZERO   = 3'd2,
		ST_INVALID   = 3'd3,
		ST_UNDERFLOW = 3'd4,
		ST_OVERFLOW  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_EXEC,
		CS_DIV
	} ctrl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic in_ready;
		logic commit;
		logic div_start;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic in_valid;
		logic need_div;
		logic div_done;
		logic out_free;
	} dp_stat_t;

endpackage

[rtl/smeu_ifs.sv]
// Valid/ready channel interfaces for the execute unit: instruction in, result out.
// Depends on smeu_pkg for field widths.
interface smeu_in_if
	import smeu_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          operation;
	logic signed [DATA_W-1:0] immediate;

	modport source (output valid, output operation, output immediate, input ready);
	modport sink   (input valid, input operation, input immediate, output ready);
endinterface

interface smeu_out_if
	import smeu_pkg::*;
#(
	parameter int ADDRESS_BITS = 16
) ();
	logic                     valid;
	logic                     ready;
	logic [ST_W-1:0]          status;
	logic signed [DATA_W-1:0] value;
	logic [ADDRESS_BITS-1:0]  next_address;
	logic [ADDRESS_BITS-1:0]  fault_address;

	modport source (output valid, output status, output value, output next_address,
		output fault_address, input ready);
	modport sink   (input valid, input status, input value, input next_address,
		input fault_address, output ready);
endinterface

[rtl/smeu_div.sv]
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
// Depends on smeu_pkg.
module smeu_div
	import smeu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic [DATA_W-1:0] quotient,
	output logic              done
);

	localparam int CW = $clog2(DIV_STEPS + 1);

	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              neg_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] dsr_q;
	logic [DATA_W:0]   rem_sh;
	logic [DATA_W:0]   trial;

	// Shift in the next dividend bit and try the subtraction
	assign rem_sh = {rem_q, quo_q[DATA_W-1]};
	assign trial  = rem_sh - {1'b0, dsr_q};

	// Control: count iterations, flag completion until the next start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(DIV_STEPS);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Data: load magnitudes on start, then one restoring step a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
			quo_q <= dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
			dsr_q <= divisor[DATA_W-1] ? (~divisor + DATA_W'(1)) : divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[DATA_W]) begin
				rem_q <= trial[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	// Apply the sign; the most negative quotient wraps on its own
	assign quotient = neg_q ? (~quo_q + DATA_W'(1)) : quo_q;
	assign done     = done_q;

endmodule

[rtl/smeu_ctrl.sv]
// Controller FSM of the execute unit: accepts an instruction, sequences
// execution and the divider, and commits the result. Depends on smeu_pkg.
module smeu_ctrl
	import smeu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE: begin
				if (stat.in_valid) state_d = CS_EXEC;
			end
			CS_EXEC: begin
				if (stat.need_div) state_d = CS_DIV;
				else if (stat.out_free) state_d = CS_IDLE;
			end
			CS_DIV: begin
				if (stat.div_done && stat.out_free) state_d = CS_IDLE;
			end
			default: state_d = CS_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd = '0;
		case (state_q)
			CS_IDLE: begin
				cmd.in_ready = 1'b1;
			end
			CS_EXEC: begin
				cmd.div_start = stat.need_div;
				cmd.commit    = !stat.need_div && stat.out_free;
			end
			CS_DIV: begin
				cmd.commit = stat.div_done && stat.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

[rtl/smeu_dp.sv]
// Datapath of the execute unit: instruction latch, value stack memory,
// stack pointer, program counter, ALU, divider and result register.
// Depends on smeu_pkg, smeu_ifs and smeu_div.
module smeu_dp
	import smeu_pkg::*;
#(
	parameter int STACK_DEPTH  = 64,
	parameter int ADDRESS_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ctrl_cmd_t cmd,
	output dp_stat_t  stat,
	smeu_in_if.sink   instr,
	smeu_out_if.source result
);

	localparam int IW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int AW  = ADDRESS_BITS;

	// Architectural state
	logic [SPW-1:0]    sp_q;
	logic [AW-1:0]     pc_q;
	logic [DATA_W-1:0] mem [STACK_DEPTH];

	// Latched instruction and stack reads
	op_t               op_q;
	logic [DATA_W-1:0] imm_q;
	logic [DATA_W-1:0] top_q;
	logic [DATA_W-1:0] sec_q;

	// Result register
	logic              out_valid_q;
	status_t           status_q;
	logic [DATA_W-1:0] value_q;
	logic [AW-1:0]     next_q;
	logic [AW-1:0]     fault_q;

	// Execute signals
	logic [IW-1:0]     ra_top;
	logic [IW-1:0]     ra_sec;
	logic [AW-1:0]     after_op;
	logic [AW-1:0]     after_imm;
	logic [AW-1:0]     target;
	logic [DATA_W-1:0] alu;
	logic [DATA_W-1:0] quotient;
	logic              div_done;
	status_t           st;
	logic [DATA_W-1:0] val;
	logic [AW-1:0]     nxt;
	logic [SPW-1:0]    sp_n;
	logic              we;
	logic [IW-1:0]     wa;
	logic [DATA_W-1:0] wd;
	logic              accept;
	logic              out_free;

	assign accept   = instr.valid && cmd.in_ready;
	assign out_free = !out_valid_q || result.ready;

	// Read addresses of the two top entries, held at zero when absent
	assign ra_top = (sp_q >= SPW'(1)) ? IW'(sp_q - SPW'(1)) : '0;
	assign ra_sec = (sp_q >= SPW'(2)) ? IW'(sp_q - SPW'(2)) : '0;

	// Latch the instruction on transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_t'(instr.operation);
			imm_q <= instr.immediate;
		end
	end

	// Stack memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.commit && st == ST_RUNNING && we) mem[wa] <= wd;
		top_q <= mem[ra_top];
		sec_q <= mem[ra_sec];
	end

	smeu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sec_q),
		.divisor  (top_q),
		.quotient (quotient),
		.done     (div_done)
	);

	assign after_op  = pc_q + AW'(1);
	assign after_imm = pc_q + AW'(5);
	assign target    = imm_q[AW-1:0];

	// Arithmetic on the second (a) and top (b) entries
	always_comb begin
		case (op_q)
			OP_ADD:  alu = sec_q + top_q;
			OP_SUB:  alu = sec_q - top_q;
			OP_MUL:  alu = sec_q * top_q;
			OP_DIV:  alu = quotient;
			default: alu = '0;
		endcase
	end

	// Decode status, stack update and next fetch address
	always_comb begin
		st   = ST_RUNNING;
		val  = '0;
		nxt  = after_op;
		sp_n = sp_q;
		we   = 1'b0;
		wa   = ra_sec;
		wd   = alu;
		case (op_q)
			OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
				if (sp_q < SPW'(2)) begin
					st = ST_UNDERFLOW;
				end else if (op_q == OP_DIV && top_q == '0) begin
					st = ST_DIVZERO;
				end else begin
					we   = 1'b1;
					sp_n = sp_q - SPW'(1);
				end
			end
			OP_PUSH1, OP_PUSH0, OP_PUSHIMM: begin
				wa = IW'(sp_q);
				case (op_q)
					OP_PUSH1: wd = DATA_W'(1);
					OP_PUSH0: wd = '0;
					default:  wd = imm_q;
				endcase
				if (sp_q >= SPW'(STACK_DEPTH)) begin
					st = ST_OVERFLOW;
				end else begin
					we   = 1'b1;
					sp_n = sp_q + SPW'(1);
					if (op_q == OP_PUSHIMM) nxt = after_imm;
				end
			end
			OP_RET: begin
				st = ST_RETURNED;
			end
			OP_RETBOOL, OP_RETS32: begin
				if (sp_q < SPW'(1)) begin
					st = ST_UNDERFLOW;
				end else begin
					st  = ST_RETURNED;
					val = top_q;
				end
			end
			OP_JMP: begin
				nxt = target;
			end
			OP_JMPTRUE, OP_JMPFALSE: begin
				if (sp_q < SPW'(1)) begin
					st = ST_UNDERFLOW;
				end else begin
					sp_n = sp_q - SPW'(1);
					if ((op_q == OP_JMPTRUE) ? (top_q == DATA_W'(1)) : (top_q == '0))
						nxt = target;
					else
						nxt = after_imm;
				end
			end
			default: begin
				st = ST_INVALID;
			end
		endcase
	end

	// Commit: update sp and pc, clear both after a return or fault
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
			pc_q <= '0;
		end else if (cmd.commit) begin
			if (st == ST_RUNNING) begin
				sp_q <= sp_n;
				pc_q <= nxt;
			end else begin
				sp_q <= '0;
				pc_q <= '0;
			end
		end
	end

	// Result valid: set on commit, drop once the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= st;
			value_q  <= (st == ST_RETURNED) ? val : '0;
			next_q   <= (st == ST_RUNNING) ? nxt : '0;
			fault_q  <= (st == ST_RUNNING || st == ST_RETURNED) ? '0 : after_op;
		end
	end

	assign instr.ready          = cmd.in_ready;
	assign result.valid         = out_valid_q;
	assign result.status        = status_q;
	assign result.value         = value_q;
	assign result.next_address  = next_q;
	assign result.fault_address = fault_q;

	always_comb begin
		stat          = '0;
		stat.in_valid = instr.valid;
		stat.need_div = (op_q == OP_DIV) && (sp_q >= SPW'(2)) && (top_q != '0);
		stat.div_done = div_done;
		stat.out_free = out_free;
	end

	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(STACK_DEPTH))
		else $error("stack pointer beyond depth");

	a_fault_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && st != ST_RUNNING |=> sp_q == '0 && pc_q == '0)
		else $error("sp/pc not cleared after return or fault");

	a_commit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> out_free)
		else $error("commit while result slot is occupied");

	a_fault_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == ST_RUNNING || status_q == ST_RETURNED) |-> fault_q == '0)
		else $error("fault address set without a fault");

endmodule

[rtl/stack_machine_execute_unit_core.sv]
// Execute unit of a 32-bit stack machine: one decoded instruction per transfer.
// An accepted instruction is latched, executed, and its result registered for the
// sink; a divide also runs the bit-serial divider (one quotient bit a cycle).
// A new instruction is accepted only after the previous one commits, and a
// result held by the sink stalls the next one. Reset clears the stack pointer,
// program counter and control; stack contents are undefined until written.
module stack_machine_execute_unit_core
	import smeu_pkg::*;
#(
	parameter int STACK_DEPTH  = 64,
	parameter int ADDRESS_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	smeu_in_if.sink    instr,
	smeu_out_if.source result
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	smeu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	smeu_dp #(
		.STACK_DEPTH  (STACK_DEPTH),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.instr  (instr),
		.result (result)
	);

endmodule
